// ----- hw/rtl/rha_pkg.sv -----
// rha_pkg: sizes, codes and control types shared by the heap allocator files
// no dependencies; compile first
`timescale 1ns / 1ps
`default_nettype none

package rha_pkg;

    localparam int HEAP_DEPTH       = 65536;
    localparam int FREE_STACK_DEPTH = 64;

    localparam int HEAP_AW = $clog2(HEAP_DEPTH);
    localparam int FS_AW   = $clog2(FREE_STACK_DEPTH);
    localparam int FC_W    = $clog2(FREE_STACK_DEPTH + 1);

    localparam int ADDR_W  = 16;
    localparam int SIZE_W  = 16;
    localparam int ACT_W   = 3;
    localparam int ST_W    = 3;
    localparam int WORDS_W = 17;
    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int DYN_W   = ADDR_W + 1;
    localparam int PTR_W   = ((HEAP_AW > ADDR_W) ? HEAP_AW : ADDR_W) + 2;
    localparam int CNT_W   = ((HEAP_AW + 1 > WORDS_W) ? HEAP_AW + 1 : WORDS_W);
    localparam int SUB_W   = HALF_W + 1;

    localparam logic [PTR_W-1:0]  HEAP_DEPTH_P     = PTR_W'(HEAP_DEPTH);
    localparam logic [CNT_W-1:0]  HEAP_DEPTH_C     = CNT_W'(HEAP_DEPTH);
    localparam logic [FC_W-1:0]   FS_DEPTH_C       = FC_W'(FREE_STACK_DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_MAX         = 16'hFFFF;
    localparam logic [ADDR_W-1:0] REGION_START_RST = 16'd32768;
    localparam logic [ADDR_W-1:0] STATIC_NEXT_RST  = 16'd1;
    localparam logic [HALF_W-1:0] COUNT_ONE        = 32'd1;

    localparam logic [ACT_W-1:0] ACT_STATIC  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DYNAMIC = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INC     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEC     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FREE    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW   = 3'd1;
    localparam logic [ST_W-1:0] ST_NULL       = 3'd2;
    localparam logic [ST_W-1:0] ST_STACK_FULL = 3'd3;
    localparam logic [ST_W-1:0] ST_ZERO_COUNT = 3'd4;

    typedef struct packed {
        logic latch_in;
        logic decode;
        logic rd_top;
        logic dyn_decide;
        logic zero_step;
        logic hdr_write;
        logic ref_update;
        logic load_out;
    } rha_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             addr_zero;
        logic             size_zero;
        logic             dyn_fail;
        logic             zero_last;
    } rha_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rha_if.sv -----
// rha_if: request, response and configuration channels of the heap allocator
// depends on rha_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface rha_req_if;
    import rha_pkg::*;
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [SIZE_W-1:0] alloc_size;
    logic [ADDR_W-1:0] address;
    modport source (output valid, action, alloc_size, address, input ready);
    modport sink (input valid, action, alloc_size, address, output ready);
endinterface

interface rha_rsp_if;
    import rha_pkg::*;
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  result_address;
    logic [ST_W-1:0]    status;
    logic               freed;
    logic [WORDS_W-1:0] used_words;
    logic [WORDS_W-1:0] peak_words;
    modport source (output valid, result_address, status, freed, used_words, peak_words,
                    input ready);
    modport sink (input valid, result_address, status, freed, used_words, peak_words,
                  output ready);
endinterface

interface rha_cfg_if;
    import rha_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rha_ram.sv -----
// rha_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rha_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rha_ctrl.sv -----
// rha_ctrl: sequencer for the heap allocator, drives datapath commands
// depends on rha_pkg for command and status types
`timescale 1ns / 1ps
`default_nettype none

module rha_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    input  wire rha_pkg::rha_sts_t sts,
    output rha_pkg::rha_cmd_t      cmd
);
    import rha_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_FS_WAIT = 3'd2;
    localparam logic [2:0] S_DYN_CHK = 3'd3;
    localparam logic [2:0] S_ZERO    = 3'd4;
    localparam logic [2:0] S_HDR_WR  = 3'd5;
    localparam logic [2:0] S_REF_UPD = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       ref_action;

    assign req_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = out_valid_reg;
    assign ref_action = (sts.action == ACT_INC) || (sts.action == ACT_DEC)
                        || (sts.action == ACT_FREE);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (sts.action == ACT_DYNAMIC)
                begin
                    state_next = S_FS_WAIT;
                end
                else if (ref_action && !sts.addr_zero)
                begin
                    state_next = S_REF_UPD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FS_WAIT:
            begin
                cmd.rd_top = 1'b1;
                state_next = S_DYN_CHK;
            end
            S_DYN_CHK:
            begin
                cmd.dyn_decide = 1'b1;
                if (sts.dyn_fail)
                begin
                    state_next = S_DONE;
                end
                else if (sts.size_zero)
                begin
                    state_next = S_HDR_WR;
                end
                else
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                cmd.zero_step = 1'b1;
                if (sts.zero_last)
                begin
                    state_next = S_HDR_WR;
                end
            end
            S_HDR_WR:
            begin
                cmd.hdr_write = 1'b1;
                state_next    = S_DONE;
            end
            S_REF_UPD:
            begin
                cmd.ref_update = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rha_datapath.sv -----
// rha_datapath: heap and free stack memories, pointers, counters and result word
// depends on rha_pkg and rha_ram
`timescale 1ns / 1ps
`default_nettype none

module rha_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire rha_pkg::rha_cmd_t          cmd,
    output rha_pkg::rha_sts_t               sts,
    input  wire logic [rha_pkg::ACT_W-1:0]  action,
    input  wire logic [rha_pkg::SIZE_W-1:0] alloc_size,
    input  wire logic [rha_pkg::ADDR_W-1:0] address,
    input  wire logic                       cfg_valid,
    input  wire logic [rha_pkg::ADDR_W-1:0] cfg_data,
    output logic [rha_pkg::ADDR_W-1:0]      result_address,
    output logic [rha_pkg::ST_W-1:0]        status,
    output logic                            freed,
    output logic [rha_pkg::WORDS_W-1:0]     used_words,
    output logic [rha_pkg::WORDS_W-1:0]     peak_words
);
    import rha_pkg::*;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] u,
                                                 input logic [WORDS_W-1:0] n);
        logic [CNT_W:0] t;
        t = {1'b0, u} + (CNT_W + 1)'(n);
        if (t > {1'b0, HEAP_DEPTH_C})
        begin
            return HEAP_DEPTH_C;
        end
        return t[CNT_W-1:0];
    endfunction

    // item registers
    logic [ACT_W-1:0]  action_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] res_reg, res_next;
    logic [ST_W-1:0]   st_reg, st_next;
    logic              fr_reg, fr_next;
    logic [ADDR_W-1:0] hdr_reg, hdr_next;
    logic [SIZE_W-1:0] idx_reg, idx_next;

    // allocator state
    logic [FC_W-1:0]   free_count_reg, free_count_next;
    logic [ADDR_W-1:0] static_next_reg, static_next_next;
    logic [DYN_W-1:0]  dyn_next_reg, dyn_next_next;
    logic              started_reg, started_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  peak_reg, peak_next;
    logic [ADDR_W-1:0] region_start_reg;
    logic              rd_ok_reg, rd_ok_next;

    // memory ports
    logic               heap_we;
    logic               heap_we_req;
    logic [PTR_W-1:0]   heap_wfull;
    logic [WORD_W-1:0]  heap_wdata;
    logic [PTR_W-1:0]   heap_rfull;
    logic [WORD_W-1:0]  heap_rdata;
    logic               fs_we;
    logic [FS_AW-1:0]   fs_waddr;
    logic [FC_W-1:0]    fc_minus1;
    logic [ADDR_W-1:0]  fs_rdata;

    logic [ADDR_W-1:0]  ref_hdr;
    logic [WORD_W-1:0]  h_word;
    logic [HALF_W-1:0]  h_size;
    logic [HALF_W-1:0]  h_cnt;
    logic               reuse;
    logic [PTR_W-1:0]   dyn_sum;
    logic               dyn_fail;
    logic [PTR_W-1:0]   stat_sum;
    logic               stat_fail;
    logic [SUB_W-1:0]   sub_n;
    logic [CNT_W-1:0]   sub_res;
    logic [WORDS_W-1:0] size_plus1;
    logic               releasing;

    assign ref_hdr    = addr_reg - ADDR_W'(1);
    assign heap_rfull = cmd.rd_top ? PTR_W'(fs_rdata) : PTR_W'(ref_hdr);
    assign rd_ok_next = heap_rfull < HEAP_DEPTH_P;
    assign h_word     = rd_ok_reg ? heap_rdata : '0;
    assign h_size     = h_word[WORD_W-1:HALF_W];
    assign h_cnt      = h_word[HALF_W-1:0];
    assign fc_minus1  = free_count_reg - FC_W'(1);

    assign reuse      = (free_count_reg != '0) && (h_size >= HALF_W'(size_reg));
    assign dyn_sum    = PTR_W'(dyn_next_reg) + PTR_W'(size_reg) + PTR_W'(1);
    assign dyn_fail   = !reuse && ((dyn_sum >= HEAP_DEPTH_P)
                                   || (dyn_next_reg >= DYN_W'(ADDR_MAX)));
    assign stat_sum   = PTR_W'(static_next_reg) + PTR_W'(size_reg);
    assign stat_fail  = (stat_sum >= HEAP_DEPTH_P) || (stat_sum > PTR_W'(ADDR_MAX));
    assign sub_n      = SUB_W'(h_size) + SUB_W'(1);
    assign sub_res    = (sub_n >= SUB_W'(used_reg)) ? '0
                        : CNT_W'(SUB_W'(used_reg) - sub_n);
    assign size_plus1 = WORDS_W'(size_reg) + WORDS_W'(1);
    assign releasing  = (action_reg == ACT_FREE)
                        || ((action_reg == ACT_DEC) && (h_cnt == COUNT_ONE));

    assign sts.action    = action_reg;
    assign sts.addr_zero = (addr_reg == '0);
    assign sts.size_zero = (size_reg == '0);
    assign sts.dyn_fail  = dyn_fail;
    assign sts.zero_last = (idx_reg == size_reg);

    always_comb
    begin
        res_next         = res_reg;
        st_next          = st_reg;
        fr_next          = fr_reg;
        hdr_next         = hdr_reg;
        idx_next         = idx_reg;
        free_count_next  = free_count_reg;
        static_next_next = static_next_reg;
        dyn_next_next    = dyn_next_reg;
        started_next     = started_reg;
        used_next        = used_reg;
        heap_we_req      = 1'b0;
        heap_wfull       = PTR_W'(hdr_reg);
        heap_wdata       = '0;
        fs_we            = 1'b0;
        fs_waddr         = free_count_reg[FS_AW-1:0];

        if (cmd.latch_in)
        begin
            res_next = '0;
            st_next  = ST_OK;
            fr_next  = 1'b0;
        end

        if (cmd.decode)
        begin
            case (action_reg)
                ACT_STATIC:
                begin
                    if (addr_reg != '0)
                    begin
                        res_next  = addr_reg;
                        used_next = sat_add(used_reg, WORDS_W'(size_reg));
                    end
                    else if (stat_fail)
                    begin
                        st_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        res_next         = static_next_reg;
                        static_next_next = stat_sum[ADDR_W-1:0];
                        used_next        = sat_add(used_reg, WORDS_W'(size_reg));
                    end
                end
                ACT_DYNAMIC:
                begin
                    if (!started_reg)
                    begin
                        dyn_next_next = DYN_W'(region_start_reg);
                        started_next  = 1'b1;
                    end
                end
                ACT_INC, ACT_DEC, ACT_FREE:
                begin
                    if (addr_reg == '0)
                    begin
                        st_next = ST_NULL;
                    end
                end
                default:
                begin
                    st_next = ST_OK;
                end
            endcase
        end

        if (cmd.dyn_decide)
        begin
            if (reuse)
            begin
                hdr_next        = fs_rdata;
                free_count_next = fc_minus1;
            end
            else if (!dyn_fail)
            begin
                hdr_next      = dyn_next_reg[ADDR_W-1:0];
                dyn_next_next = dyn_sum[DYN_W-1:0];
            end

            if (dyn_fail)
            begin
                st_next = ST_OVERFLOW;
            end
            else
            begin
                used_next = sat_add(used_reg, size_plus1);
                res_next  = (reuse ? fs_rdata : dyn_next_reg[ADDR_W-1:0]) + ADDR_W'(1);
                idx_next  = SIZE_W'(1);
            end
        end

        if (cmd.zero_step)
        begin
            heap_we_req = 1'b1;
            heap_wfull  = PTR_W'(hdr_reg) + PTR_W'(idx_reg);
            heap_wdata  = '0;
            idx_next    = idx_reg + SIZE_W'(1);
        end

        if (cmd.hdr_write)
        begin
            heap_we_req = 1'b1;
            heap_wfull  = PTR_W'(hdr_reg);
            heap_wdata  = {HALF_W'(size_reg), COUNT_ONE};
        end

        if (cmd.ref_update)
        begin
            heap_wfull = PTR_W'(ref_hdr);
            if (action_reg == ACT_INC)
            begin
                heap_we_req = 1'b1;
                heap_wdata  = {h_size, h_cnt + COUNT_ONE};
            end
            else if ((action_reg == ACT_DEC) && (h_cnt == '0))
            begin
                st_next = ST_ZERO_COUNT;
            end
            else if (action_reg == ACT_DEC)
            begin
                heap_we_req = 1'b1;
                heap_wdata  = {h_size, h_cnt - COUNT_ONE};
            end

            if (releasing && !((action_reg == ACT_DEC) && (h_cnt == '0)))
            begin
                fr_next   = 1'b1;
                used_next = sub_res;
                if (free_count_reg < FS_DEPTH_C)
                begin
                    fs_we           = 1'b1;
                    free_count_next = free_count_reg + FC_W'(1);
                end
                else
                begin
                    st_next = ST_STACK_FULL;
                end
            end
        end

        peak_next = (used_next > peak_reg) ? used_next : peak_reg;
    end

    assign heap_we = heap_we_req && (heap_wfull < HEAP_DEPTH_P);

    rha_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HEAP_DEPTH)
    ) u_heap (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_wfull[HEAP_AW-1:0]),
        .wdata (heap_wdata),
        .raddr (heap_rfull[HEAP_AW-1:0]),
        .rdata (heap_rdata)
    );

    rha_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (FREE_STACK_DEPTH)
    ) u_free_stack (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (ref_hdr),
        .raddr (fc_minus1[FS_AW-1:0]),
        .rdata (fs_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg   <= '0;
            static_next_reg  <= STATIC_NEXT_RST;
            dyn_next_reg     <= '0;
            started_reg      <= 1'b0;
            used_reg         <= '0;
            peak_reg         <= '0;
            region_start_reg <= REGION_START_RST;
            rd_ok_reg        <= 1'b0;
        end
        else
        begin
            free_count_reg  <= free_count_next;
            static_next_reg <= static_next_next;
            dyn_next_reg    <= dyn_next_next;
            started_reg     <= started_next;
            used_reg        <= used_next;
            peak_reg        <= peak_next;
            rd_ok_reg       <= rd_ok_next;
            if (cfg_valid)
            begin
                region_start_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            action_reg <= action;
            size_reg   <= alloc_size;
            addr_reg   <= address;
        end
        res_reg <= res_next;
        st_reg  <= st_next;
        fr_reg  <= fr_next;
        hdr_reg <= hdr_next;
        idx_reg <= idx_next;
        if (cmd.load_out)
        begin
            result_address <= res_next;
            status         <= st_next;
            freed          <= fr_next;
            used_words     <= used_next[WORDS_W-1:0];
            peak_words     <= peak_next[WORDS_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/refcount_heap_allocator_core.sv -----
// Reference-counted heap allocator with bump pointers and a LIFO free stack.
// req carries one word per operation: action, alloc_size, address.
//   action 0 static alloc, 1 dynamic alloc, 2 add reference, 3 drop reference,
//   4 free block. rsp returns one word per request: result_address, status,
//   freed, used_words and peak_words after the operation.
// cfg writes dynamic_region_start; it is always ready. The user must write it
// only while idle; the block itself does not enforce this. One request is in
// flight at a time; req.ready is high only when the sequencer is idle. A
// dynamic alloc zeroes its payload one heap word per cycle through the single
// heap write port before the header is written; an overflowing one skips both.
// The result sits in an output register; a new request is accepted while it
// waits, and only the completion of the next one waits for rsp.ready.
// Reset (rst_n low, asynchronous) empties the free stack, sets the static
// pointer to 1, clears the counters and restores dynamic_region_start to 32768.
// Heap contents are not cleared and need no clearing pass.
// Depends on rha_pkg, rha_if, rha_ram, rha_ctrl and rha_datapath.
`timescale 1ns / 1ps
`default_nettype none

module refcount_heap_allocator_core (
    input wire logic  clk,
    input wire logic  rst_n,
    rha_req_if.sink   req,
    rha_rsp_if.source rsp,
    rha_cfg_if.sink   cfg
);
    import rha_pkg::*;

    rha_cmd_t cmd;
    rha_sts_t sts;

    assign cfg.ready = 1'b1;

    rha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rha_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .action         (req.action),
        .alloc_size     (req.alloc_size),
        .address        (req.address),
        .cfg_valid      (cfg.valid),
        .cfg_data       (cfg.data),
        .result_address (rsp.result_address),
        .status         (rsp.status),
        .freed          (rsp.freed),
        .used_words     (rsp.used_words),
        .peak_words     (rsp.peak_words)
    );

endmodule

`default_nettype wire

// ----- tb/sv/refcount_heap_allocator_core_test.sv -----
// refcount_heap_allocator_core_test: self-checking bench for the heap allocator core
// depends on rha_pkg, rha_if and the core RTL; predicts every response word in
// its own heap model and compares it field by field
`timescale 1ns / 1ps

module refcount_heap_allocator_core_test;
    import rha_pkg::*;

    localparam int STALL_LIMIT = 300000;

    typedef struct packed {
        logic [ADDR_W-1:0]  result_address;
        logic [ST_W-1:0]    status;
        logic               freed;
        logic [WORDS_W-1:0] used_words;
        logic [WORDS_W-1:0] peak_words;
    } heap_reply_t;

    logic clk;
    logic rst_n;

    rha_req_if req_ch ();
    rha_rsp_if rsp_ch ();
    rha_cfg_if cfg_ch ();

    refcount_heap_allocator_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    bit [WORD_W-1:0]    heap_mem [HEAP_DEPTH];
    bit                 heap_written [HEAP_DEPTH];
    logic [ADDR_W-1:0]  free_hdrs [FREE_STACK_DEPTH];
    logic [FC_W-1:0]    free_depth;
    logic [ADDR_W-1:0]  static_ptr;
    logic [DYN_W-1:0]   dyn_ptr;
    logic               dyn_started;
    logic [WORDS_W-1:0] used_w;
    logic [WORDS_W-1:0] peak_w;
    logic [ADDR_W-1:0]  region_start;

    heap_reply_t        expected_replies [$];
    logic [ADDR_W-1:0]  live_blocks [$];

    int src_idle_pct;
    int snk_idle_pct;
    int rsp_hold_len;
    int mismatches;
    int n_sent;
    int n_checked;
    int n_dyn;
    int n_released;
    int n_cfg;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void heap_store(int unsigned idx, bit [WORD_W-1:0] val);
        if (idx < HEAP_DEPTH)
        begin
            heap_mem[idx] = val;
            heap_written[idx] = 1'b1;
        end
    endfunction

    function automatic void used_add(int unsigned n);
        int unsigned t;
        t = used_w + n;
        if (t > HEAP_DEPTH)
            t = HEAP_DEPTH;
        used_w = WORDS_W'(t);
        if (used_w > peak_w)
            peak_w = used_w;
    endfunction

    function automatic void block_release(int unsigned hdr, inout heap_reply_t r);
        int unsigned sz;
        sz = heap_mem[hdr][WORD_W-1:HALF_W];
        if (sz + 1 >= used_w)
            used_w = '0;
        else
            used_w = WORDS_W'(used_w - (sz + 1));
        if (free_depth < FS_DEPTH_C)
        begin
            free_hdrs[free_depth] = ADDR_W'(hdr);
            free_depth++;
        end
        else
            r.status = ST_STACK_FULL;
        r.freed = 1'b1;
    endfunction

    function automatic heap_reply_t heap_apply(logic [ACT_W-1:0] act, logic [SIZE_W-1:0] sz,
                                               logic [ADDR_W-1:0] ad);
        heap_reply_t r;
        int unsigned nxt;
        int unsigned hdr;
        bit [WORD_W-1:0] h;
        bit ok;
        r = '0;
        case (act)
            ACT_STATIC:
            begin
                if (ad != 0)
                begin
                    r.result_address = ad;
                    used_add(32'(sz));
                end
                else
                begin
                    nxt = static_ptr + sz;
                    if (nxt >= HEAP_DEPTH || nxt > ADDR_MAX)
                        r.status = ST_OVERFLOW;
                    else
                    begin
                        r.result_address = static_ptr;
                        static_ptr = ADDR_W'(nxt);
                        used_add(32'(sz));
                    end
                end
            end
            ACT_DYNAMIC:
            begin
                ok = 1'b1;
                if (!dyn_started)
                begin
                    dyn_ptr = DYN_W'(region_start);
                    dyn_started = 1'b1;
                end
                if (free_depth != 0 &&
                    heap_mem[free_hdrs[free_depth - 1]][WORD_W-1:HALF_W] >= sz)
                begin
                    hdr = 32'(free_hdrs[free_depth - 1]);
                    free_depth--;
                end
                else
                begin
                    hdr = 32'(dyn_ptr);
                    nxt = dyn_ptr + sz + 1;
                    if (nxt >= HEAP_DEPTH || hdr >= ADDR_MAX)
                    begin
                        ok = 1'b0;
                        r.status = ST_OVERFLOW;
                    end
                    else
                        dyn_ptr = DYN_W'(nxt);
                end
                if (ok)
                begin
                    used_add(int'(sz) + 1);
                    for (int unsigned i = 1; i <= sz; i++)
                        heap_store(hdr + i, '0);
                    heap_store(hdr, {HALF_W'(sz), COUNT_ONE});
                    r.result_address = ADDR_W'(hdr + 1);
                end
            end
            ACT_INC, ACT_DEC, ACT_FREE:
            begin
                if (ad == 0)
                    r.status = ST_NULL;
                else
                begin
                    hdr = ad - 1;
                    h = heap_mem[hdr];
                    if (act == ACT_INC)
                        heap_store(hdr, {h[WORD_W-1:HALF_W], h[HALF_W-1:0] + COUNT_ONE});
                    else if (act == ACT_DEC)
                    begin
                        if (h[HALF_W-1:0] == 0)
                            r.status = ST_ZERO_COUNT;
                        else
                        begin
                            h[HALF_W-1:0] = h[HALF_W-1:0] - 1;
                            heap_store(hdr, h);
                            if (h[HALF_W-1:0] == 0)
                                block_release(hdr, r);
                        end
                    end
                    else
                        block_release(hdr, r);
                end
            end
            default: ;
        endcase
        r.used_words = used_w;
        r.peak_words = peak_w;
        return r;
    endfunction

    // an address whose header word holds a known value, or 0 when no block is listed as live
    function automatic logic [ADDR_W-1:0] pick_ref_address();
        logic [ADDR_W-1:0] a;
        if ($urandom_range(9) == 0)
        begin
            for (int k = 0; k < 8; k++)
            begin
                a = ADDR_W'($urandom_range(1, 65535));
                if (heap_written[a - 1])
                    return a;
            end
        end
        if (live_blocks.size() == 0)
            return '0;
        return live_blocks[$urandom_range(live_blocks.size() - 1)];
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(999);
        if (r < 700)
            return SIZE_W'($urandom_range(0, 8));
        else if (r < 960)
            return SIZE_W'($urandom_range(9, 64));
        else if (r < 995)
            return SIZE_W'($urandom_range(65, 1024));
        return SIZE_W'($urandom_range(1025, 65535));
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_request(logic [ACT_W-1:0] act, logic [SIZE_W-1:0] sz,
                                logic [ADDR_W-1:0] ad);
        heap_reply_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.alloc_size <= sz;
        req_ch.address    <= ad;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        r = heap_apply(act, sz, ad);
        expected_replies.insert(expected_replies.size(), r);
        n_sent++;
        if (r.freed)
            n_released++;
        if (act == ACT_DYNAMIC && r.status == ST_OK)
        begin
            n_dyn++;
            live_blocks.insert(live_blocks.size(), r.result_address);
            if (live_blocks.size() > 256)
                void'(live_blocks.pop_front());
        end
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_region_start(logic [ADDR_W-1:0] val);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        region_start = val;
        n_cfg++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_region_config();
        write_region_start(ADDR_MAX);
        write_region_start(ADDR_W'(1));
        write_region_start(ADDR_W'($urandom_range(1, 32768)));
    endtask

    task automatic test_directed();
        logic [ADDR_W-1:0] blk;
        send_request(ACT_STATIC, '0, '0);
        send_request(ACT_STATIC, SIZE_W'(5), '0);
        send_request(ACT_STATIC, SIZE_W'(3), ADDR_MAX);
        send_request(ACT_STATIC, 16'hFFFF, '0);
        send_request(ACT_DYNAMIC, '0, '0);
        send_request(ACT_DYNAMIC, SIZE_W'(8), '0);
        blk = live_blocks[$];
        send_request(ACT_INC, '0, blk);
        send_request(ACT_DEC, '0, blk);
        send_request(ACT_DEC, '0, blk);
        // count already zero, then a second free of the same block
        send_request(ACT_DEC, '0, blk);
        send_request(ACT_FREE, '0, blk);
        // reuse with a smaller size, then a size the shrunk header no longer fits
        send_request(ACT_DYNAMIC, SIZE_W'(4), '0);
        send_request(ACT_DYNAMIC, SIZE_W'(8), '0);
        send_request(ACT_DYNAMIC, 16'hFFFF, 16'hFFFF);
        send_request(ACT_INC, 16'hFFFF, '0);
        send_request(ACT_DEC, '0, '0);
        send_request(ACT_FREE, '0, '0);
        for (int a = 5; a < 8; a++)
            send_request(ACT_W'(a), 16'hFFFF, ADDR_MAX);
    endtask

    task automatic test_mixed(int n);
        int unsigned r;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 7)
                send_request(ACT_STATIC, pick_size(), ADDR_W'($urandom_range(1, 65535)));
            else if (r < 14)
                send_request(ACT_STATIC, pick_size(), '0);
            else if (r < 46)
                send_request(ACT_DYNAMIC, pick_size(), ADDR_W'($urandom));
            else if (r < 60)
                send_request(ACT_INC, SIZE_W'($urandom), pick_ref_address());
            else if (r < 80)
                send_request(ACT_DEC, SIZE_W'($urandom), pick_ref_address());
            else if (r < 88)
                send_request(ACT_FREE, SIZE_W'($urandom), pick_ref_address());
            else if (r < 93)
                send_request(ACT_W'(ACT_INC + $urandom_range(2)), SIZE_W'($urandom), '0);
            else
                send_request(ACT_W'($urandom_range(5, 7)), SIZE_W'($urandom),
                             ADDR_W'($urandom));
        end
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        int saved;
        saved = src_idle_pct;
        src_idle_pct = 0;
        rsp_hold_len = 400;
        repeat (16)
        begin
            if ($urandom_range(1))
                send_request(ACT_DYNAMIC, SIZE_W'($urandom_range(0, 3)), '0);
            else
                send_request(ACT_INC, '0, pick_ref_address());
        end
        src_idle_pct = saved;
    endtask

    // enough frees in a row to overfill the free stack, then pops
    task automatic test_free_stack_burst();
        repeat (70) send_request(ACT_FREE, '0, pick_ref_address());
        repeat (10) send_request(ACT_DYNAMIC, '0, '0);
    endtask

    task automatic test_used_saturation();
        send_request(ACT_STATIC, 16'hFFFF, ADDR_W'($urandom_range(1, 65535)));
        send_request(ACT_STATIC, 16'hFFFF, ADDR_W'($urandom_range(1, 65535)));
        send_request(ACT_FREE, '0, pick_ref_address());
        send_request(ACT_STATIC, SIZE_W'(2), ADDR_MAX);
    endtask

    initial
    begin : rsp_side
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_len > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (rsp_hold_len) @(negedge clk);
                rsp_hold_len = 0;
            end
            rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin : rsp_check
        heap_reply_t want;
        heap_reply_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.result_address = rsp_ch.result_address;
                got.status         = rsp_ch.status;
                got.freed          = rsp_ch.freed;
                got.used_words     = rsp_ch.used_words;
                got.peak_words     = rsp_ch.peak_words;
                n_checked++;
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected response word, expected none actual %p",
                             $time, got);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("result_address", 32'(want.result_address),
                                32'(got.result_address));
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("freed", 32'(want.freed), 32'(got.freed));
                    check_field("used_words", 32'(want.used_words), 32'(got.used_words));
                    check_field("peak_words", 32'(want.peak_words), 32'(got.peak_words));
                end
            end
        end
    end

    initial
    begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                stall = 0;
            else
                stall++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : main_flow
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = '0;
        req_ch.alloc_size = '0;
        req_ch.address    = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        src_idle_pct      = 0;
        snk_idle_pct      = 0;
        rsp_hold_len      = 0;
        mismatches        = 0;
        n_sent            = 0;
        n_checked         = 0;
        n_dyn             = 0;
        n_released        = 0;
        n_cfg             = 0;
        free_depth        = '0;
        static_ptr        = STATIC_NEXT_RST;
        dyn_ptr           = '0;
        dyn_started       = 1'b0;
        used_w            = '0;
        peak_w            = '0;
        region_start      = REGION_START_RST;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_region_config();
        test_directed();

        src_idle_pct = 22;
        snk_idle_pct = 64;
        test_mixed(520);
        test_backpressure();
        write_region_start(ADDR_MAX);

        src_idle_pct = 64;
        snk_idle_pct = 22;
        test_mixed(520);
        test_free_stack_burst();
        write_region_start(ADDR_W'(1));

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_mixed(460);
        test_used_saturation();

        wait_idle();
        repeat (20) @(negedge clk);
        $display("sent %0d requests with %0d region writes: %0d dynamic blocks placed, %0d released",
                 n_sent, n_cfg, n_dyn, n_released);
        $display("checked %0d response words, %0d field mismatches", n_checked, mismatches);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
